// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the timer pool RTL. Bodies are empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/mcst_pkg.sv =====
// ----------------------------------------------------------------------------
// mcst_pkg
// Types and constants shared by the millisecond timer pool.
// ----------------------------------------------------------------------------
package mcst_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int POOL_CAP       = 64;   // sizes the extended slot index; slot fields hold IDX_W bits
    localparam int RES_MAX        = 16;   // expiries reported per tick at most
    localparam int HITS_W         = $clog2(RES_MAX + 1);

    localparam int OP_W       = 3;
    localparam int IDX_W      = 4;
    localparam int TIME_W     = 32;
    localparam int TAG_W      = 16;
    localparam int DLY_W      = 16;
    localparam int SLOT_EXT_W = $clog2(POOL_CAP + 1);

    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 24;

    localparam logic KIND_REPLY  = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 3'd0,
        OP_ALLOC = 3'd1,
        OP_FREE  = 3'd2,
        OP_START = 3'd3,
        OP_STOP  = 3'd4,
        OP_PAUSE = 3'd5,
        OP_CONT  = 3'd6,
        OP_DELAY = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_FREE  = 2'd0,
        ST_IDLE  = 2'd1,
        ST_RUN   = 2'd2,
        ST_PAUSE = 2'd3
    } t_status;

    typedef struct packed {
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] deadline;
        logic [TIME_W-1:0] remaining;
        logic [TIME_W-1:0] cycles;
        logic              fvr;
        logic              ntf;
        logic [TAG_W-1:0]  tag;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // packed from the top down, so kind lands in bit 0
    typedef struct packed {
        logic              last;
        logic              finished;
        logic              wants_notify;
        logic [TAG_W-1:0]  tag_out;
        logic [IDX_W-1:0]  slot;
        logic              ok;
        logic              kind;
    } t_result;

endpackage

// ===== rtl/mcst_ram.sv =====
// ----------------------------------------------------------------------------
// mcst_ram
// Simple dual-port RAM, one write and one read port, registered read with
// read enable (data holds while the enable is low).
// ----------------------------------------------------------------------------
module mcst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/multi_channel_soft_timer.sv =====
// ----------------------------------------------------------------------------
// multi_channel_soft_timer
// Pool of millisecond timers. One operation per input transfer: tick,
// allocate, free, start, stop, pause, continue, delay. Timer entries live in
// one RAM; slot status sits in flops so that allocate can search it.
// ----------------------------------------------------------------------------
//  channel   dir  tdata (low bit up)                       tuser        tlast
//  s_axis    in   timer_index, period_ms, cycle_count,     opcode       -
//                 forever_req, notify, user_tag,
//                 extra_delay_ms, pad
//  m_axis    out  ok, slot, tag_out, wants_notify,         result_kind  last
//                 finished, pad
//
//  Operations other than tick: accept, then one RAM read-modify-write.
//  Tick: one slot per cycle through the RAM read port unless a stalled m_axis
//  holds the scan; the sixteenth expiry ends the scan early.
//  A stalled m_axis also holds other operations; one result waits in the
//  output register while the scan goes on. No clearing pass after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module multi_channel_soft_timer #(
    parameter int NUM_TIMERS = mcst_pkg::NUM_TIMERS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // timer_index, period_ms, cycle_count, forever_req, notify, user_tag,
    // extra_delay_ms, pad
    input  logic [mcst_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // opcode
    input  logic [mcst_pkg::OP_W-1:0]        s_axis_tuser,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // ok, slot, tag_out, wants_notify, finished, pad
    output logic [mcst_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // result_kind
    output logic                             m_axis_tuser,
    output logic                             m_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready
);

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int SW = mcst_pkg::SLOT_EXT_W;
    localparam int TW = mcst_pkg::TIME_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_OP,
        S_SCAN,
        S_FLUSH
    } t_state;

    // input fields
    logic [mcst_pkg::IDX_W-1:0] in_idx;
    logic [TW-1:0]              in_per;
    logic [TW-1:0]              in_cyc;
    logic                       in_fev;
    logic                       in_ntf;
    logic [mcst_pkg::TAG_W-1:0] in_tag;
    logic [mcst_pkg::DLY_W-1:0] in_dly;
    mcst_pkg::t_op              in_op;
    logic                       in_acc;

    assign in_idx = s_axis_tdata[3:0];
    assign in_per = s_axis_tdata[35:4];
    assign in_cyc = s_axis_tdata[67:36];
    assign in_fev = s_axis_tdata[68];
    assign in_ntf = s_axis_tdata[69];
    assign in_tag = s_axis_tdata[85:70];
    assign in_dly = s_axis_tdata[101:86];
    assign in_op  = mcst_pkg::t_op'(s_axis_tuser);

    // registers
    t_state                      r_state;
    mcst_pkg::t_op               r_op;
    logic [mcst_pkg::IDX_W-1:0]  r_idx;
    logic [TW-1:0]               r_per;
    logic [TW-1:0]               r_cyc;
    logic                        r_fev;
    logic                        r_ntf;
    logic [mcst_pkg::TAG_W-1:0]  r_tag;
    logic [mcst_pkg::DLY_W-1:0]  r_dly;
    logic [TW-1:0]               r_now;
    mcst_pkg::t_status           r_status [NUM_TIMERS];
    logic [IW-1:0]               r_ev_idx;
    logic [mcst_pkg::HITS_W-1:0] r_hits;
    logic                        r_pend_v;
    mcst_pkg::t_result           r_pend;
    logic                        r_m_valid;
    mcst_pkg::t_result           r_m_data;

    // RAM port
    logic                        wr_en;
    logic [IW-1:0]               wr_addr;
    mcst_pkg::t_entry            wr_data;
    logic                        rd_en;
    logic [IW-1:0]               rd_addr;
    mcst_pkg::t_entry            rd_data;
    logic [mcst_pkg::ENTRY_W-1:0] rd_word;

    mcst_ram #(
        .WIDTH (mcst_pkg::ENTRY_W),
        .DEPTH (NUM_TIMERS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_word)
    );

    assign rd_data = mcst_pkg::t_entry'(rd_word);

    // first free slot
    logic          free_found;
    logic [IW-1:0] free_idx;

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
            if (r_status[i] == mcst_pkg::ST_FREE) begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end

    logic [SW-1:0] in_idx_ext;
    logic [SW-1:0] op_idx_ext;
    logic [IW-1:0] op_addr;
    logic          op_in_range;

    assign in_idx_ext  = SW'(in_idx);
    assign op_idx_ext  = SW'(r_idx);
    assign op_addr     = op_idx_ext[IW-1:0];
    assign op_in_range = op_idx_ext < SW'(NUM_TIMERS);

    logic out_free;
    assign out_free = !r_m_valid || m_axis_tready;

    // next-state logic
    t_state            n_state;
    logic              out_load;
    mcst_pkg::t_result n_out;
    logic              st_we;
    logic [IW-1:0]     st_addr;
    mcst_pkg::t_status st_val;
    logic              pend_load;
    logic              pend_clr;
    mcst_pkg::t_result n_pend;
    logic              ev_adv;
    mcst_pkg::t_status op_st;
    mcst_pkg::t_status ev_st;
    logic              ev_hit;
    logic              ev_fin;
    logic [SW-1:0]     ev_idx_ext;
    logic [IW-1:0]     ev_nxt;
    logic [SW-1:0]     free_ext;

    assign op_st      = r_status[op_addr];
    assign ev_st      = r_status[r_ev_idx];
    assign ev_idx_ext = SW'(r_ev_idx);
    assign ev_nxt     = r_ev_idx + IW'(1);
    assign free_ext   = SW'(free_idx);
    assign ev_hit     = (ev_st == mcst_pkg::ST_RUN) && !(r_now < rd_data.deadline);

    always_comb begin
        n_state   = r_state;
        out_load  = 1'b0;
        n_out     = '0;
        wr_en     = 1'b0;
        wr_addr   = r_ev_idx;
        wr_data   = rd_data;
        rd_en     = 1'b1;
        rd_addr   = ev_nxt;
        st_we     = 1'b0;
        st_addr   = r_ev_idx;
        st_val    = mcst_pkg::ST_FREE;
        pend_load = 1'b0;
        pend_clr  = 1'b0;
        n_pend    = '0;
        ev_adv    = 1'b0;
        ev_fin    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                rd_addr = (in_op == mcst_pkg::OP_TICK) ? '0 : in_idx_ext[IW-1:0];
                if (in_acc) begin
                    n_state = (in_op == mcst_pkg::OP_TICK) ? S_SCAN : S_OP;
                end
            end

            S_OP: begin
                n_out.kind = mcst_pkg::KIND_REPLY;
                n_out.last = 1'b1;
                n_out.slot = r_idx;
                wr_addr    = op_addr;
                st_addr    = op_addr;
                if (r_op == mcst_pkg::OP_ALLOC) begin
                    n_out.ok   = free_found;
                    n_out.slot = free_ext[mcst_pkg::IDX_W-1:0];
                    st_we      = free_found;
                    st_addr    = free_idx;
                    st_val     = mcst_pkg::ST_IDLE;
                end else if (op_in_range) begin
                    unique case (r_op)
                        mcst_pkg::OP_FREE: begin
                            n_out.ok = op_st != mcst_pkg::ST_FREE;
                            st_we    = n_out.ok;
                            st_val   = mcst_pkg::ST_FREE;
                        end
                        mcst_pkg::OP_START: begin
                            n_out.ok         = op_st != mcst_pkg::ST_FREE;
                            st_we            = n_out.ok;
                            st_val           = mcst_pkg::ST_RUN;
                            wr_en            = n_out.ok;
                            wr_data.period   = r_per;
                            wr_data.deadline = r_per + r_now;
                            wr_data.cycles   = r_cyc;
                            wr_data.fvr      = r_fev;
                            wr_data.ntf      = r_ntf;
                            wr_data.tag      = r_tag;
                        end
                        mcst_pkg::OP_STOP: begin
                            n_out.ok = op_st != mcst_pkg::ST_FREE;
                            st_we    = n_out.ok;
                            st_val   = mcst_pkg::ST_IDLE;
                        end
                        mcst_pkg::OP_PAUSE: begin
                            n_out.ok = (op_st == mcst_pkg::ST_RUN)
                                       && (r_now < rd_data.deadline);
                            st_we             = n_out.ok;
                            st_val            = mcst_pkg::ST_PAUSE;
                            wr_en             = n_out.ok;
                            wr_data.remaining = rd_data.deadline - r_now;
                        end
                        mcst_pkg::OP_CONT: begin
                            n_out.ok         = op_st == mcst_pkg::ST_PAUSE;
                            st_we            = n_out.ok;
                            st_val           = mcst_pkg::ST_RUN;
                            wr_en            = n_out.ok;
                            wr_data.deadline = rd_data.remaining + r_now;
                        end
                        mcst_pkg::OP_DELAY: begin
                            n_out.ok         = op_st == mcst_pkg::ST_RUN;
                            wr_en            = n_out.ok;
                            wr_data.deadline = r_now + TW'(r_dly);
                        end
                        default: begin
                            n_out.ok = 1'b0;
                        end
                    endcase
                end
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    // hold everything, read data included
                    rd_en = 1'b0;
                    wr_en = 1'b0;
                    st_we = 1'b0;
                end
            end

            S_SCAN: begin
                if (ev_hit && r_pend_v && !out_free) begin
                    rd_en = 1'b0;
                end else begin
                    ev_adv = 1'b1;
                    if (ev_hit) begin
                        wr_en = 1'b1;
                        if (rd_data.fvr) begin
                            wr_data.deadline = rd_data.period + r_now;
                        end else if (rd_data.cycles <= TW'(1)) begin
                            wr_data.cycles = '0;
                            st_we          = 1'b1;
                            st_val         = mcst_pkg::ST_IDLE;
                            ev_fin         = 1'b1;
                        end else begin
                            wr_data.cycles   = rd_data.cycles - TW'(1);
                            wr_data.deadline = rd_data.period + r_now;
                        end
                        // the previous expiry is not the last one
                        out_load            = r_pend_v;
                        n_out               = r_pend;
                        pend_load           = 1'b1;
                        n_pend.kind         = mcst_pkg::KIND_EXPIRY;
                        n_pend.ok           = 1'b1;
                        n_pend.slot         = ev_idx_ext[mcst_pkg::IDX_W-1:0];
                        n_pend.tag_out      = rd_data.tag;
                        n_pend.wants_notify = rd_data.ntf;
                        n_pend.finished     = ev_fin;
                        n_pend.last         = 1'b0;
                    end
                    if ((r_ev_idx == IW'(NUM_TIMERS - 1))
                        || (ev_hit && (r_hits == mcst_pkg::HITS_W'(mcst_pkg::RES_MAX - 1))))
                    begin
                        n_state = S_FLUSH;
                    end
                end
            end

            S_FLUSH: begin
                if (!r_pend_v) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    out_load   = 1'b1;
                    n_out      = r_pend;
                    n_out.last = 1'b1;
                    pend_clr   = 1'b1;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_now     <= '0;
            r_ev_idx  <= '0;
            r_hits    <= '0;
            r_pend_v  <= 1'b0;
            r_m_valid <= 1'b0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                r_status[i] <= mcst_pkg::ST_FREE;
            end
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_op  <= in_op;
                r_idx <= in_idx;
                r_per <= in_per;
                r_cyc <= in_cyc;
                r_fev <= in_fev;
                r_ntf <= in_ntf;
                r_tag <= in_tag;
                r_dly <= in_dly;
                if (in_op == mcst_pkg::OP_TICK) begin
                    r_now    <= r_now + TW'(1);
                    r_ev_idx <= '0;
                    r_hits   <= '0;
                end
            end
            if (ev_adv) begin
                r_ev_idx <= ev_nxt;
                if (ev_hit) begin
                    r_hits <= r_hits + mcst_pkg::HITS_W'(1);
                end
            end
            if (st_we) begin
                r_status[st_addr] <= st_val;
            end
            if (pend_load) begin
                r_pend_v <= 1'b1;
                r_pend   <= n_pend;
            end else if (pend_clr) begin
                r_pend_v <= 1'b0;
            end
            if (out_load) begin
                r_m_valid <= 1'b1;
                r_m_data  <= n_out;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_data.kind;
    assign m_axis_tlast  = r_m_data.last;
    assign m_axis_tdata  = {1'b0, r_m_data.finished, r_m_data.wants_notify,
                            r_m_data.tag_out, r_m_data.slot, r_m_data.ok};

    `ASSERT_CLK(a_hits_cap, i_clk, i_rst_n,
        (r_state == S_SCAN) |-> (r_hits < mcst_pkg::HITS_W'(mcst_pkg::RES_MAX)),
        "expiry count passed its cap")
    `ASSERT_CLK(a_pend_idle, i_clk, i_rst_n,
        (r_state == S_IDLE) |-> !r_pend_v,
        "expiry left pending after a tick")
    `ASSERT_CLK(a_reply_last, i_clk, i_rst_n,
        (r_m_valid && (r_m_data.kind == mcst_pkg::KIND_REPLY)) |-> r_m_data.last,
        "reply without last")
    `ASSERT_CLK(a_tick_now, i_clk, i_rst_n,
        (in_acc && (in_op == mcst_pkg::OP_TICK)) |=> (r_now == $past(r_now) + TW'(1)),
        "tick did not advance the counter")
    `ASSERT_ALWAYS(a_rst_idle, i_clk,
        !i_rst_n |=> (r_state == S_IDLE) && !r_m_valid,
        "reset did not clear control")

endmodule
